@@ rtl/ps2dec_pkg.sv @@
// Shared types, codes and key tables of the PS/2 set 2 scan code decoder.
package ps2dec_pkg;

  localparam logic [7:0] BYTE_BREAK = 8'hF0;
  localparam logic [7:0] BYTE_EXT   = 8'hE0;
  localparam logic [7:0] BYTE_PAUSE = 8'hE1;
  localparam logic [7:0] BYTE_PRTSC = 8'h7C;
  localparam logic [7:0] BYTE_LSHFT = 8'h12;

  localparam logic [7:0] KEY_NONE   = 8'd255;
  localparam logic [7:0] KEY_PRTSC  = 8'd45;   // row 1, col 13
  localparam logic [7:0] KEY_SCROLL = 8'd46;   // row 1, col 14
  localparam logic [7:0] KEY_PAUSE  = 8'd47;   // row 1, col 15
  localparam logic [7:0] KEY_NUM    = 8'd81;   // row 2, col 17
  localparam logic [7:0] KEY_CAPS   = 8'd128;  // row 4, col 0
  localparam logic [7:0] KEY_LSHIFT = 8'd160;
  localparam logic [7:0] KEY_RSHIFT = 8'd172;
  localparam logic [7:0] KEY_LCTRL  = 8'd192;
  localparam logic [7:0] KEY_RCTRL  = 8'd199;
  localparam logic [7:0] KEY_LGUI   = 8'd193;
  localparam logic [7:0] KEY_RGUI   = 8'd197;
  localparam logic [7:0] KEY_LALT   = 8'd194;
  localparam logic [7:0] KEY_RALT   = 8'd196;
  localparam logic [7:0] KEY_CHARS  = 8'd224;

  localparam logic [3:0] LEN_PAUSE       = 4'd8;
  localparam logic [3:0] LEN_PRINT_MAKE  = 4'd4;
  localparam logic [3:0] LEN_PRINT_BREAK = 4'd6;
  localparam logic [3:0] LEN_MAX         = 4'd15;

  typedef struct packed {
    logic caps;
    logic num;
    logic scroll;
    logic alt;
    logic gui;
    logic ctrl;
    logic shift;
  } flags_t;

  typedef struct packed {
    logic [7:0] keycode;
    logic       pressed;
    logic [6:0] ascii;
    flags_t     flags;
  } evt_t;

  function automatic logic [7:0] lookup_single(input logic [7:0] code);
    logic [7:0] k;
    unique case (code)
      8'h76: k = 8'd32;  8'h05: k = 8'd33;  8'h06: k = 8'd34;  8'h04: k = 8'd35;
      8'h0C: k = 8'd36;  8'h03: k = 8'd37;  8'h0B: k = 8'd38;  8'h83: k = 8'd39;
      8'h0A: k = 8'd40;  8'h01: k = 8'd41;  8'h09: k = 8'd42;  8'h78: k = 8'd43;
      8'h07: k = 8'd44;  8'h7E: k = 8'd46;
      8'h0E: k = 8'd64;  8'h16: k = 8'd65;  8'h1E: k = 8'd66;  8'h26: k = 8'd67;
      8'h25: k = 8'd68;  8'h2E: k = 8'd69;  8'h36: k = 8'd70;  8'h3D: k = 8'd71;
      8'h3E: k = 8'd72;  8'h46: k = 8'd73;  8'h45: k = 8'd74;  8'h4E: k = 8'd75;
      8'h55: k = 8'd76;  8'h66: k = 8'd77;  8'h77: k = 8'd81;  8'h7C: k = 8'd83;
      8'h7B: k = 8'd84;
      8'h0D: k = 8'd96;  8'h15: k = 8'd97;  8'h1D: k = 8'd98;  8'h24: k = 8'd99;
      8'h2D: k = 8'd100; 8'h2C: k = 8'd101; 8'h35: k = 8'd102; 8'h3C: k = 8'd103;
      8'h43: k = 8'd104; 8'h44: k = 8'd105; 8'h4D: k = 8'd106; 8'h54: k = 8'd107;
      8'h5B: k = 8'd108; 8'h5D: k = 8'd109; 8'h6C: k = 8'd113; 8'h75: k = 8'd114;
      8'h7D: k = 8'd115; 8'h79: k = 8'd116;
      8'h58: k = 8'd128; 8'h1C: k = 8'd129; 8'h1B: k = 8'd130; 8'h23: k = 8'd131;
      8'h2B: k = 8'd132; 8'h34: k = 8'd133; 8'h33: k = 8'd134; 8'h3B: k = 8'd135;
      8'h42: k = 8'd136; 8'h4B: k = 8'd137; 8'h4C: k = 8'd138; 8'h52: k = 8'd139;
      8'h5A: k = 8'd140; 8'h6B: k = 8'd141; 8'h73: k = 8'd142; 8'h74: k = 8'd143;
      8'h12: k = 8'd160; 8'h61: k = 8'd161; 8'h1A: k = 8'd162; 8'h22: k = 8'd163;
      8'h21: k = 8'd164; 8'h2A: k = 8'd165; 8'h32: k = 8'd166; 8'h31: k = 8'd167;
      8'h3A: k = 8'd168; 8'h41: k = 8'd169; 8'h49: k = 8'd170; 8'h4A: k = 8'd171;
      8'h59: k = 8'd172; 8'h69: k = 8'd174; 8'h72: k = 8'd175; 8'h7A: k = 8'd176;
      8'h14: k = 8'd192; 8'h11: k = 8'd194; 8'h29: k = 8'd195; 8'h70: k = 8'd203;
      8'h71: k = 8'd204;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] lookup_ext(input logic [7:0] code);
    logic [7:0] k;
    unique case (code)
      8'h37: k = 8'd0;   8'h3F: k = 8'd1;   8'h5E: k = 8'd2;   8'h4D: k = 8'd3;
      8'h15: k = 8'd4;   8'h3B: k = 8'd5;   8'h34: k = 8'd6;   8'h23: k = 8'd7;
      8'h32: k = 8'd8;   8'h21: k = 8'd9;   8'h50: k = 8'd10;  8'h48: k = 8'd11;
      8'h2B: k = 8'd12;  8'h40: k = 8'd13;  8'h10: k = 8'd14;  8'h3A: k = 8'd15;
      8'h38: k = 8'd16;  8'h30: k = 8'd17;  8'h28: k = 8'd18;  8'h20: k = 8'd19;
      8'h18: k = 8'd20;
      8'h70: k = 8'd78;  8'h6C: k = 8'd79;  8'h7D: k = 8'd80;  8'h4A: k = 8'd82;
      8'h71: k = 8'd110; 8'h69: k = 8'd111; 8'h7A: k = 8'd112; 8'h75: k = 8'd173;
      8'h5A: k = 8'd177; 8'h14: k = 8'd199; 8'h1F: k = 8'd193; 8'h6B: k = 8'd200;
      8'h72: k = 8'd201; 8'h74: k = 8'd202; 8'h11: k = 8'd196; 8'h27: k = 8'd197;
      8'h2F: k = 8'd198;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  // German layout, shifted plane picked by sh
  function automatic logic [6:0] layout_char(input logic [7:0] key, input logic sh);
    logic [7:0] c;
    unique case (key)
      8'd64:  c = sh ? 8'h00 : "^";
      8'd65:  c = sh ? "!"   : "1";
      8'd66:  c = sh ? "\""  : "2";
      8'd67:  c = sh ? 8'h00 : "3";
      8'd68:  c = sh ? "$"   : "4";
      8'd69:  c = sh ? "%"   : "5";
      8'd70:  c = sh ? "&"   : "6";
      8'd71:  c = sh ? "/"   : "7";
      8'd72:  c = sh ? "("   : "8";
      8'd73:  c = sh ? ")"   : "9";
      8'd74:  c = sh ? "="   : "0";
      8'd75:  c = sh ? "?"   : 8'h00;
      8'd82:  c = "/";
      8'd83:  c = "*";
      8'd84:  c = "-";
      8'd96:  c = "\t";
      8'd97:  c = sh ? "Q" : "q";
      8'd98:  c = sh ? "W" : "w";
      8'd99:  c = sh ? "E" : "e";
      8'd100: c = sh ? "R" : "r";
      8'd101: c = sh ? "T" : "t";
      8'd102: c = sh ? "Z" : "z";
      8'd103: c = sh ? "U" : "u";
      8'd104: c = sh ? "I" : "i";
      8'd105: c = sh ? "O" : "o";
      8'd106: c = sh ? "P" : "p";
      8'd108: c = sh ? "*" : "+";
      8'd109: c = sh ? "'" : "#";
      8'd113: c = "7";
      8'd114: c = "8";
      8'd115: c = "9";
      8'd116: c = "+";
      8'd129: c = sh ? "A" : "a";
      8'd130: c = sh ? "S" : "s";
      8'd131: c = sh ? "D" : "d";
      8'd132: c = sh ? "F" : "f";
      8'd133: c = sh ? "G" : "g";
      8'd134: c = sh ? "H" : "h";
      8'd135: c = sh ? "J" : "j";
      8'd136: c = sh ? "K" : "k";
      8'd137: c = sh ? "L" : "l";
      8'd140: c = "\n";
      8'd141: c = "4";
      8'd142: c = "5";
      8'd143: c = "6";
      8'd161: c = sh ? ">" : "<";
      8'd162: c = sh ? "Y" : "y";
      8'd163: c = sh ? "X" : "x";
      8'd164: c = sh ? "C" : "c";
      8'd165: c = sh ? "V" : "v";
      8'd166: c = sh ? "B" : "b";
      8'd167: c = sh ? "N" : "n";
      8'd168: c = sh ? "M" : "m";
      8'd169: c = sh ? ";" : ",";
      8'd170: c = sh ? ":" : ".";
      8'd171: c = sh ? "_" : "-";
      8'd174: c = "1";
      8'd175: c = "2";
      8'd176: c = "3";
      8'd177: c = "\n";
      8'd195: c = " ";
      8'd203: c = "0";
      8'd204: c = ".";
      default: c = 8'h00;
    endcase
    return c[6:0];
  endfunction

endpackage

@@ rtl/ps2dec_if.sv @@
// Byte and event channel interfaces of the scan code decoder.
interface ps2dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;
  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2dec_evt_if;
  logic       valid;
  logic       ready;
  logic [7:0] keycode;
  logic       pressed;
  logic [6:0] ascii;
  logic       shift_held;
  logic       ctrl_held;
  logic       gui_held;
  logic       alt_held;
  logic       scroll_lock_on;
  logic       num_lock_on;
  logic       caps_lock_on;
  modport source (output valid, output keycode, output pressed, output ascii,
                  output shift_held, output ctrl_held, output gui_held, output alt_held,
                  output scroll_lock_on, output num_lock_on, output caps_lock_on,
                  input ready);
  modport sink   (input valid, input keycode, input pressed, input ascii,
                  input shift_held, input ctrl_held, input gui_held, input alt_held,
                  input scroll_lock_on, input num_lock_on, input caps_lock_on,
                  output ready);
endinterface

@@ rtl/ps2_set2_scancode_decoder.sv @@
// PS/2 set 2 scan code decoder: prefix tracking, key map, flags, layout lookup.
// An event is registered into the output queue when its last byte beat is accepted.
// Throughput: one byte per cycle unless the input stalls; decode, table lookup and key map update
// sit between the state registers and a two-entry output queue.
// Input stalls only when both output queue entries are held.
// Reset (synchronous, rst_n low) clears phase, length, key map, flags, queue.
module ps2_set2_scancode_decoder
  import ps2dec_pkg::*;
#(
  parameter int MAX_SEQUENCE_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ps2dec_byte_if.sink          in_if,
  ps2dec_evt_if.source         out_if
);

  typedef enum logic [1:0] {PH_START, PH_EXT, PH_BREAK, PH_LONG} phase_t;

  phase_t       phase_r, phase_nxt;
  logic [7:0]   seq_r   [MAX_SEQUENCE_BYTES];
  logic [7:0]   seq_nxt [MAX_SEQUENCE_BYTES];
  logic [3:0]   len_r, len_nxt;
  logic [255:0] pmap_r;
  flags_t       flags_r, flags_nxt;

  evt_t         slot_r [2];
  logic [1:0]   cnt_r;

  logic         accept, pop, emit;
  logic [7:0]   b, key;
  logic         press, store;
  logic         wr_en;
  logic [3:0]   wr_pos;
  logic [3:0]   len_inc, target;
  logic         m_pause, m_pmake, m_pbreak;
  evt_t         evt;

  assign accept = in_if.valid && in_if.ready;
  assign pop    = out_if.valid && out_if.ready;
  assign b      = in_if.scan_byte;
  assign in_if.ready = (cnt_r != 2'd2);

  assign len_inc = (len_r < LEN_MAX) ? len_r + 4'd1 : len_r;

  // byte array as it stands after this beat's write
  always_comb begin
    for (int i = 0; i < MAX_SEQUENCE_BYTES; i++) begin
      seq_nxt[i] = (wr_en && wr_pos == 4'(i)) ? b : seq_r[i];
    end
  end

  assign m_pause  = seq_nxt[0] == 8'hE1 && seq_nxt[1] == 8'h14 && seq_nxt[2] == 8'h77 &&
                    seq_nxt[3] == 8'hE1 && seq_nxt[4] == 8'hF0 && seq_nxt[5] == 8'h14 &&
                    seq_nxt[6] == 8'hF0 && seq_nxt[7] == 8'h77;
  assign m_pmake  = seq_nxt[0] == 8'hE0 && seq_nxt[1] == 8'h12 && seq_nxt[2] == 8'hE0 &&
                    seq_nxt[3] == 8'h7C;
  assign m_pbreak = seq_nxt[0] == 8'hE0 && seq_nxt[1] == 8'hF0 && seq_nxt[2] == 8'h7C &&
                    seq_nxt[3] == 8'hE0 && seq_nxt[4] == 8'hF0 && seq_nxt[5] == 8'h12;

  always_comb begin
    if (seq_nxt[0] == BYTE_PAUSE)      target = LEN_PAUSE;
    else if (seq_nxt[1] == BYTE_LSHFT) target = LEN_PRINT_MAKE;
    else                               target = LEN_PRINT_BREAK;
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    wr_en     = 1'b0;
    wr_pos    = 4'd0;
    emit      = 1'b0;
    key       = KEY_NONE;
    press     = 1'b1;
    unique case (phase_r)
      PH_START: begin
        if (b == BYTE_PAUSE) begin
          phase_nxt = PH_LONG;  wr_en = 1'b1; wr_pos = 4'd0;
        end else if (b == BYTE_BREAK) begin
          phase_nxt = PH_BREAK; wr_en = 1'b1; wr_pos = 4'd0;
        end else if (b == BYTE_EXT) begin
          phase_nxt = PH_EXT;   wr_en = 1'b1; wr_pos = 4'd0;
        end else begin
          emit = 1'b1; key = lookup_single(b);
        end
      end
      PH_EXT: begin
        if (b == BYTE_BREAK) begin
          phase_nxt = PH_BREAK; wr_en = 1'b1; wr_pos = 4'd1;
        end else if (b == BYTE_LSHFT) begin
          phase_nxt = PH_LONG;  wr_en = 1'b1; wr_pos = 4'd1;
        end else begin
          emit = 1'b1; key = lookup_ext(b);
        end
      end
      PH_BREAK: begin
        if (len_r >= 4'd2) begin
          if (b == BYTE_PRTSC) begin
            phase_nxt = PH_LONG; wr_en = 1'b1; wr_pos = 4'd2;
          end else begin
            emit = 1'b1; key = lookup_ext(b); press = 1'b0;
          end
        end else if (b == BYTE_PAUSE) begin
          phase_nxt = PH_LONG; wr_en = 1'b1; wr_pos = 4'd0;
        end else begin
          emit = 1'b1; key = lookup_single(b); press = 1'b0;
        end
      end
      PH_LONG: begin
        wr_en   = 32'(len_r) < MAX_SEQUENCE_BYTES;
        wr_pos  = len_r;
        len_nxt = len_inc;
        if (len_inc >= target) begin
          emit = 1'b1;
          if (target == LEN_PAUSE) begin
            key = m_pause ? KEY_PAUSE : KEY_NONE;
          end else if (target == LEN_PRINT_MAKE) begin
            key = m_pmake ? KEY_PRTSC : KEY_NONE;
          end else begin
            key = m_pbreak ? KEY_PRTSC : KEY_NONE; press = 1'b0;
          end
        end
      end
      default: ;
    endcase
    // prefix bytes set the length to position plus one
    if (phase_r != PH_LONG && wr_en) len_nxt = wr_pos + 4'd1;
    if (emit) begin
      phase_nxt = PH_START;
      len_nxt   = 4'd0;
    end
  end

  assign store = key != KEY_PAUSE && key != KEY_SCROLL && key != KEY_NUM && key != KEY_CAPS;

  function automatic logic map_bit(input logic [255:0] m, input logic [7:0] k,
                                   input logic [7:0] kw, input logic st, input logic pv);
    return (st && kw == k) ? pv : m[k];
  endfunction

  always_comb begin
    flags_nxt        = '0;
    flags_nxt.scroll = flags_r.scroll ^ (press && key == KEY_SCROLL);
    flags_nxt.num    = flags_r.num    ^ (press && key == KEY_NUM);
    flags_nxt.caps   = flags_r.caps   ^ (press && key == KEY_CAPS);
    flags_nxt.shift  = map_bit(pmap_r, KEY_LSHIFT, key, store, press) |
                       map_bit(pmap_r, KEY_RSHIFT, key, store, press);
    flags_nxt.ctrl   = map_bit(pmap_r, KEY_LCTRL, key, store, press) |
                       map_bit(pmap_r, KEY_RCTRL, key, store, press);
    flags_nxt.gui    = map_bit(pmap_r, KEY_LGUI, key, store, press) |
                       map_bit(pmap_r, KEY_RGUI, key, store, press);
    flags_nxt.alt    = map_bit(pmap_r, KEY_LALT, key, store, press) |
                       map_bit(pmap_r, KEY_RALT, key, store, press);
  end

  always_comb begin
    evt.keycode = key;
    evt.pressed = press;
    evt.ascii   = (key < KEY_CHARS) ? layout_char(key, flags_r.shift | flags_r.caps) : 7'd0;
    evt.flags   = flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      len_r   <= 4'd0;
      pmap_r  <= '0;
      flags_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      if (emit) begin
        flags_r <= flags_nxt;
        if (store) pmap_r[key] <= press;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_SEQUENCE_BYTES; i++) seq_r[i] <= seq_nxt[i];
    end
  end

  // two-entry output queue: head in slot 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      unique case ({accept && emit, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({accept && emit, pop})
      2'b10: begin
        if (cnt_r == 2'd0) slot_r[0] <= evt;
        else               slot_r[1] <= evt;
      end
      2'b01: slot_r[0] <= slot_r[1];
      2'b11: begin
        if (cnt_r == 2'd1) begin
          slot_r[0] <= evt;
        end else begin
          slot_r[0] <= slot_r[1];
          slot_r[1] <= evt;
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid          = cnt_r != 2'd0;
  assign out_if.keycode        = slot_r[0].keycode;
  assign out_if.pressed        = slot_r[0].pressed;
  assign out_if.ascii          = slot_r[0].ascii;
  assign out_if.shift_held     = slot_r[0].flags.shift;
  assign out_if.ctrl_held      = slot_r[0].flags.ctrl;
  assign out_if.gui_held       = slot_r[0].flags.gui;
  assign out_if.alt_held       = slot_r[0].flags.alt;
  assign out_if.scroll_lock_on = slot_r[0].flags.scroll;
  assign out_if.num_lock_on    = slot_r[0].flags.num;
  assign out_if.caps_lock_on   = slot_r[0].flags.caps;

endmodule

@@ rtl/ps2dec_chk.sv @@
// Port-level checks of the scan code decoder and their bind.
module ps2dec_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] keycode,
  input logic [6:0] ascii
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("event shown after reset");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && keycode == 8'd255 |-> ascii == 7'd0)
    else $error("unknown key carries a character");

  a_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ascii != 7'd0 |-> keycode < 8'd224)
    else $error("character outside layout rows");

endmodule

bind ps2_set2_scancode_decoder ps2dec_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .keycode   (out_if.keycode),
  .ascii     (out_if.ascii)
);

@@ dv/ps2dec_tb_if.sv @@
`timescale 1ns / 100ps
// Interfaces are provided by the RTL; this file holds the shared beat struct for the bench.
package ps2dec_tb_pkg;
  typedef struct packed {
    logic [7:0] keycode;
    logic       pressed;
    logic [6:0] ascii;
    logic [6:0] flags;  // caps num scroll alt gui ctrl shift
  } key_event_t;
endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the PS/2 set 2 scan code decoder: directed and random byte streams,
// a cycle-free event predictor and an in-order event scoreboard.
module tb_top;
  import ps2dec_pkg::*;
  import ps2dec_tb_pkg::*;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_EXT   = 2'd1;
  localparam logic [1:0] PH_BRK   = 2'd2;
  localparam logic [1:0] PH_LONG  = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  ps2dec_byte_if in_if();
  ps2dec_evt_if  out_if();

  ps2_set2_scancode_decoder DUT (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));

  // predictor state
  logic [1:0] dec_phase;
  logic [7:0] seq_buf [8];
  logic [3:0] seq_len;
  logic       key_down [256];
  logic [6:0] mod_flags;

  logic [7:0]  byte_queue [$];
  key_event_t  event_queue [$];
  int          mismatches = 0;
  bit          stim_done = 0;
  bit          quiet_mode = 0;
  int          events_seen = 0;
  int          bytes_sent = 0;
  logic        in_acc = 1'b0;

  function automatic logic [7:0] single_key(input logic [7:0] c);
    case (c)
      8'h76: return 32;  8'h05: return 33;  8'h06: return 34;  8'h04: return 35;
      8'h0C: return 36;  8'h03: return 37;  8'h0B: return 38;  8'h83: return 39;
      8'h0A: return 40;  8'h01: return 41;  8'h09: return 42;  8'h78: return 43;
      8'h07: return 44;  8'h7E: return 46;
      8'h0E: return 64;  8'h16: return 65;  8'h1E: return 66;  8'h26: return 67;
      8'h25: return 68;  8'h2E: return 69;  8'h36: return 70;  8'h3D: return 71;
      8'h3E: return 72;  8'h46: return 73;  8'h45: return 74;  8'h4E: return 75;
      8'h55: return 76;  8'h66: return 77;  8'h77: return 81;  8'h7C: return 83;
      8'h7B: return 84;
      8'h0D: return 96;  8'h15: return 97;  8'h1D: return 98;  8'h24: return 99;
      8'h2D: return 100; 8'h2C: return 101; 8'h35: return 102; 8'h3C: return 103;
      8'h43: return 104; 8'h44: return 105; 8'h4D: return 106; 8'h54: return 107;
      8'h5B: return 108; 8'h5D: return 109; 8'h6C: return 113; 8'h75: return 114;
      8'h7D: return 115; 8'h79: return 116;
      8'h58: return 128; 8'h1C: return 129; 8'h1B: return 130; 8'h23: return 131;
      8'h2B: return 132; 8'h34: return 133; 8'h33: return 134; 8'h3B: return 135;
      8'h42: return 136; 8'h4B: return 137; 8'h4C: return 138; 8'h52: return 139;
      8'h5A: return 140; 8'h6B: return 141; 8'h73: return 142; 8'h74: return 143;
      8'h12: return 160; 8'h61: return 161; 8'h1A: return 162; 8'h22: return 163;
      8'h21: return 164; 8'h2A: return 165; 8'h32: return 166; 8'h31: return 167;
      8'h3A: return 168; 8'h41: return 169; 8'h49: return 170; 8'h4A: return 171;
      8'h59: return 172; 8'h69: return 174; 8'h72: return 175; 8'h7A: return 176;
      8'h14: return 192; 8'h11: return 194; 8'h29: return 195; 8'h70: return 203;
      8'h71: return 204;
      default: return KEY_NONE;
    endcase
  endfunction

  function automatic logic [7:0] ext_key(input logic [7:0] c);
    case (c)
      8'h37: return 0;   8'h3F: return 1;   8'h5E: return 2;   8'h4D: return 3;
      8'h15: return 4;   8'h3B: return 5;   8'h34: return 6;   8'h23: return 7;
      8'h32: return 8;   8'h21: return 9;   8'h50: return 10;  8'h48: return 11;
      8'h2B: return 12;  8'h40: return 13;  8'h10: return 14;  8'h3A: return 15;
      8'h38: return 16;  8'h30: return 17;  8'h28: return 18;  8'h20: return 19;
      8'h18: return 20;
      8'h70: return 78;  8'h6C: return 79;  8'h7D: return 80;  8'h4A: return 82;
      8'h71: return 110; 8'h69: return 111; 8'h7A: return 112; 8'h75: return 173;
      8'h5A: return 177; 8'h14: return 199; 8'h1F: return 193; 8'h6B: return 200;
      8'h72: return 201; 8'h74: return 202; 8'h11: return 196; 8'h27: return 197;
      8'h2F: return 198;
      default: return KEY_NONE;
    endcase
  endfunction

  // German layout characters, string per row plane; '~' marks a key without one
  function automatic logic [6:0] german_char(input logic [7:0] k, input logic up);
    string lo, hi;
    int    idx;
    byte   ch;
    lo = "";
    hi = "";
    idx = 0;
    if (k >= 64 && k <= 84) begin
      lo = "^1234567890~~~~~~~/*-";
      hi = "~!\"~$%&/()=?~~~~~~/*-";
      idx = k - 64;
    end else if (k >= 96 && k <= 116) begin
      lo = "\tqwertzuiop~+#~~~789+";
      hi = "\tQWERTZUIOP~*'~~~789+";
      idx = k - 96;
    end else if (k >= 128 && k <= 143) begin
      lo = "~asdfghjkl~~\n456";
      hi = "~ASDFGHJKL~~\n456";
      idx = k - 128;
    end else if (k >= 160 && k <= 177) begin
      lo = "~<yxcvbnm,.-~~123\n";
      hi = "~>YXCVBNM;:_~~123\n";
      idx = k - 160;
    end else if (k == 195) return 7'h20;
    else if (k == 203) return 7'h30;
    else if (k == 204) return 7'h2E;
    if (lo.len() == 0) return 7'h00;
    ch = up ? hi[idx] : lo[idx];
    if (ch == "~") return 7'h00;
    return ch[6:0];
  endfunction

  function automatic void fire_event(input logic [7:0] k, input logic down);
    key_event_t e;
    logic [6:0] nf;
    e.keycode = k;
    e.pressed = down;
    e.ascii = german_char(k, mod_flags[0] | mod_flags[6]);
    if (k != KEY_PAUSE && k != KEY_SCROLL && k != KEY_NUM && k != KEY_CAPS)
      key_down[k] = down;
    nf = mod_flags & 7'b1110000;
    nf[0] = key_down[KEY_LSHIFT] | key_down[KEY_RSHIFT];
    nf[1] = key_down[KEY_LCTRL] | key_down[KEY_RCTRL];
    nf[2] = key_down[KEY_LGUI] | key_down[KEY_RGUI];
    nf[3] = key_down[KEY_LALT] | key_down[KEY_RALT];
    if (down) begin
      if (k == KEY_SCROLL) nf[4] = ~nf[4];
      if (k == KEY_NUM) nf[5] = ~nf[5];
      if (k == KEY_CAPS) nf[6] = ~nf[6];
    end
    mod_flags = nf;
    e.flags = nf;
    dec_phase = PH_START;
    seq_len = 0;
    event_queue.push_back(e);
  endfunction

  function automatic void open_seq(input logic [1:0] ph, input int pos, input logic [7:0] b);
    seq_buf[pos] = b;
    seq_len = 4'(pos + 1);
    dec_phase = ph;
  endfunction

  function automatic bit seq_is(input logic [7:0] pat [8], input int n);
    for (int i = 0; i < n; i++)
      if (seq_buf[i] !== pat[i]) return 0;
    return 1;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [7:0] pat_pause [8];
    logic [7:0] pat_pmk [8];
    logic [7:0] pat_pbk [8];
    int target;
    pat_pause = '{8'hE1, 8'h14, 8'h77, 8'hE1, 8'hF0, 8'h14, 8'hF0, 8'h77};
    pat_pmk = '{8'hE0, 8'h12, 8'hE0, 8'h7C, 0, 0, 0, 0};
    pat_pbk = '{8'hE0, 8'hF0, 8'h7C, 8'hE0, 8'hF0, 8'h12, 0, 0};
    case (dec_phase)
      PH_START: begin
        if (b == BYTE_PAUSE) open_seq(PH_LONG, 0, b);
        else if (b == BYTE_BREAK) open_seq(PH_BRK, 0, b);
        else if (b == BYTE_EXT) open_seq(PH_EXT, 0, b);
        else fire_event(single_key(b), 1'b1);
      end
      PH_EXT: begin
        if (b == BYTE_BREAK) open_seq(PH_BRK, 1, b);
        else if (b == BYTE_LSHFT) open_seq(PH_LONG, 1, b);
        else fire_event(ext_key(b), 1'b1);
      end
      PH_BRK: begin
        if (seq_len >= 2) begin
          if (b == BYTE_PRTSC) open_seq(PH_LONG, 2, b);
          else fire_event(ext_key(b), 1'b0);
        end else if (b == BYTE_PAUSE) open_seq(PH_LONG, 0, b);
        else fire_event(single_key(b), 1'b0);
      end
      default: begin
        if (seq_len < 8) seq_buf[seq_len] = b;
        if (seq_len < 15) seq_len++;
        if (seq_buf[0] == BYTE_PAUSE) target = 8;
        else if (seq_buf[1] == BYTE_LSHFT) target = 4;
        else target = 6;
        if (seq_len >= target) begin
          if (target == 8) fire_event(seq_is(pat_pause, 8) ? KEY_PAUSE : KEY_NONE, 1'b1);
          else if (target == 4) fire_event(seq_is(pat_pmk, 4) ? KEY_PRTSC : KEY_NONE, 1'b1);
          else fire_event(seq_is(pat_pbk, 6) ? KEY_PRTSC : KEY_NONE, 1'b0);
        end
      end
    endcase
  endfunction

  // note each accepting edge for the driver
  always @(posedge clk) begin
    in_acc <= rst_n && in_if.valid && in_if.ready;
  end

  // driver: advance on accepted beat, hold a waiting beat, idle in random bursts
  int src_idle = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.scan_byte <= 8'h00;
    end else begin
      if (in_acc) begin
        decode_byte(in_if.scan_byte);
        bytes_sent++;
        void'(byte_queue.pop_front());
      end
      if (in_if.valid && !in_acc) begin
        in_if.valid <= 1'b1;
      end else if (src_idle > 0) begin
        src_idle--;
        in_if.valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        if (!quiet_mode && $urandom_range(0, 15) == 0) begin
          src_idle = $urandom_range(1, 9);
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid <= 1'b1;
          in_if.scan_byte <= byte_queue[0];
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  int sink_idle = 0;
  always @(negedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else if (sink_idle > 0) begin
      sink_idle--;
      out_if.ready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 12) == 0) begin
      sink_idle = $urandom_range(1, 9);
      out_if.ready <= 1'b0;
    end else out_if.ready <= 1'b1;
  end

  // monitor: compare each event beat with the oldest prediction
  always @(posedge clk) begin
    key_event_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.keycode = out_if.keycode;
      got.pressed = out_if.pressed;
      got.ascii = out_if.ascii;
      got.flags = {out_if.caps_lock_on, out_if.num_lock_on, out_if.scroll_lock_on,
                   out_if.alt_held, out_if.gui_held, out_if.ctrl_held, out_if.shift_held};
      events_seen++;
      if (event_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event: key %0d", got.keycode);
      end else begin
        want = event_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: exp key %0d prs %0b asc %h flg %b, got %0d %0b %h %b",
                     want.keycode, want.pressed, want.ascii, want.flags,
                     got.keycode, got.pressed, got.ascii, got.flags);
        end
      end
    end
  end

  function automatic void push_seq(input logic [7:0] s [$]);
    foreach (s[i]) byte_queue.push_back(s[i]);
  endfunction

  // pick a well-formed key stroke or a broken one
  function automatic void push_random_stroke();
    logic [7:0] codes_s [$];
    logic [7:0] codes_e [$];
    logic [7:0] c;
    int kind;
    codes_s = '{8'h12, 8'h59, 8'h14, 8'h11, 8'h58, 8'h77, 8'h7E, 8'h1C, 8'h4E, 8'h16,
                8'h1E, 8'h26, 8'h45, 8'h15, 8'h35, 8'h5B, 8'h5D, 8'h61, 8'h41, 8'h4A,
                8'h29, 8'h70, 8'h71, 8'h83, 8'h0D, 8'h5A, 8'h6B, 8'h7C, 8'h21, 8'h3A};
    codes_e = '{8'h14, 8'h11, 8'h1F, 8'h27, 8'h2F, 8'h4A, 8'h5A, 8'h75, 8'h37, 8'h70,
                8'h6B, 8'h72, 8'h18};
    kind = $urandom_range(0, 19);
    if (kind < 7) begin
      c = codes_s[$urandom_range(0, codes_s.size() - 1)];
      push_seq('{c});
      if ($urandom_range(0, 1)) push_seq('{BYTE_BREAK, c});
    end else if (kind < 10) begin
      c = codes_s[$urandom_range(0, codes_s.size() - 1)];
      push_seq('{BYTE_BREAK, c});
    end else if (kind < 13) begin
      c = codes_e[$urandom_range(0, codes_e.size() - 1)];
      push_seq('{BYTE_EXT, c});
      if ($urandom_range(0, 1)) push_seq('{BYTE_EXT, BYTE_BREAK, c});
    end else if (kind == 13) begin
      push_seq('{8'hE0, 8'h12, 8'hE0, 8'h7C});
      if ($urandom_range(0, 1)) push_seq('{8'hE0, 8'hF0, 8'h7C, 8'hE0, 8'hF0, 8'h12});
    end else if (kind == 14) begin
      push_seq('{8'hE1, 8'h14, 8'h77, 8'hE1, 8'hF0, 8'h14, 8'hF0, 8'h77});
    end else if (kind == 15) begin
      // broken long sequence with random tail
      c = 8'($urandom());
      case ($urandom_range(0, 2))
        0: push_seq('{8'hE1, 8'h14, c, 8'hE1, 8'hF0, 8'h14, 8'hF0, 8'($urandom())});
        1: push_seq('{8'hE0, 8'h12, c, 8'($urandom())});
        default: push_seq('{8'hE0, 8'hF0, 8'h7C, c, 8'($urandom()), 8'($urandom())});
      endcase
    end else begin
      byte_queue.push_back(8'($urandom()));
    end
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.scan_byte = 8'h00;
    out_if.ready = 1'b0;
    dec_phase = PH_START;
    seq_len = 0;
    mod_flags = 0;
    foreach (key_down[i]) key_down[i] = 1'b0;
    foreach (seq_buf[i]) seq_buf[i] = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: field extremes, locks, modifiers, unknowns and the long sequences
    push_seq('{8'h00, 8'hFF, 8'h58, 8'h15, 8'h12, 8'h15, 8'hF0, 8'h12,
               8'h7E, 8'h77, 8'hF0, 8'hE0, 8'hF0, 8'hF0, 8'hF0, 8'hE1,
               8'h14, 8'h77, 8'hE1, 8'hF0, 8'h14, 8'hF0, 8'h77});
    push_seq('{8'hE0, 8'h12, 8'hE0, 8'h7C, 8'hE0, 8'hF0, 8'h7C, 8'hE0, 8'hF0, 8'h12,
               8'hE0, 8'hF0, 8'h12, 8'hE0, 8'h12, 8'hAA, 8'h55, 8'hE0, 8'h11, 8'h58});
    wait (byte_queue.size() == 0);
    // hold the sender until every predicted event has drained
    wait (event_queue.size() == 0);
    repeat (4) @(posedge clk);

    while (bytes_sent < 440) begin
      if (byte_queue.size() < 16) push_random_stroke();
      @(posedge clk);
    end
    // final stretch runs without idling
    quiet_mode = 1;
    repeat (20) push_random_stroke();
    wait (byte_queue.size() == 0);
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    wait (event_queue.size() == 0);
    repeat (20) @(posedge clk);
    $display("Run covered %0d scan bytes and %0d key events incl. locks, prefixes,",
             bytes_sent, events_seen);
    $display("pause and print screen sequences, broken sequences and unknown codes.");
    if (mismatches == 0 && event_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Verification failed");
    $finish;
  end
endmodule

@@ ps2_set2_scancode_decoder.f @@
rtl/ps2dec_pkg.sv
rtl/ps2dec_if.sv
rtl/ps2_set2_scancode_decoder.sv
rtl/ps2dec_chk.sv
dv/ps2dec_tb_if.sv
dv/tb_top.sv
